/* hdl/ptwd_pkg.sv */
`default_nettype none

package ptwd_pkg;

  // Queue between the classifier and the decode stage
  localparam int QUEUE_DEPTH = 2;

  // Code points of the 5-bit alphabet
  localparam logic [4:0] CODE_SPACE       = 5'd0;
  localparam logic [4:0] CODE_NEWLINE     = 5'd1;
  localparam logic [4:0] CODE_SHIFT_UPPER = 5'd2;
  localparam logic [4:0] CODE_SHIFT_SYM   = 5'd3;
  localparam logic [4:0] CODE_LOCK_UPPER  = 5'd4;
  localparam logic [4:0] CODE_LOCK_SYM    = 5'd5;
  localparam logic [4:0] CODE_FIRST_CHAR  = 5'd6;

  // ASCII values
  localparam logic [6:0] ASCII_SPACE   = 7'h20;
  localparam logic [6:0] ASCII_NL      = 7'h0A;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_QUEST   = 7'h3F;

  typedef enum logic [1:0] {
    ALPHA_LOWER  = 2'd0,
    ALPHA_UPPER  = 2'd1,
    ALPHA_SYMBOL = 2'd2
  } alpha_t;

  typedef enum logic [1:0] {
    CLS_SPACE_NL = 2'd0,
    CLS_SHIFT    = 2'd1,
    CLS_LOCK     = 2'd2,
    CLS_CHAR     = 2'd3
  } code_cls_t;

  // One classified code; idx is the character index, or the newline flag in bit 0
  typedef struct packed {
    code_cls_t  cls;
    alpha_t     alpha;
    logic [4:0] idx;
  } code_t;

  // One classified word; codes[2] is decoded first
  typedef struct packed {
    code_t [2:0] codes;
    logic        eos;
  } word_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic   pop;
    alpha_t locked;
    logic   shift_pending;
  } back_status_t;

  // Symbol alphabet; indexes past the table give '?'
  function automatic logic [6:0] sym_char(input logic [4:0] idx);
    logic [6:0] c;
    unique case (idx)
      5'd0:    c = 7'h30;
      5'd1:    c = 7'h31;
      5'd2:    c = 7'h32;
      5'd3:    c = 7'h33;
      5'd4:    c = 7'h34;
      5'd5:    c = 7'h35;
      5'd6:    c = 7'h36;
      5'd7:    c = 7'h37;
      5'd8:    c = 7'h38;
      5'd9:    c = 7'h39;
      5'd10:   c = 7'h2E;
      5'd11:   c = 7'h2C;
      5'd12:   c = 7'h21;
      5'd13:   c = 7'h3F;
      5'd14:   c = 7'h5F;
      5'd15:   c = 7'h23;
      5'd16:   c = 7'h27;
      5'd17:   c = 7'h22;
      5'd18:   c = 7'h2F;
      5'd19:   c = 7'h5C;
      5'd20:   c = 7'h2D;
      5'd21:   c = 7'h3A;
      5'd22:   c = 7'h28;
      5'd23:   c = 7'h29;
      default: c = ASCII_QUEST;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/ptwd_ifs.sv */
`default_nettype none

// Input word channel
interface ptwd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink   (input valid, input packed_word, output ready);
endinterface

// Decoded result channel
interface ptwd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] first_char;
  logic [6:0] second_char;
  logic [6:0] third_char;
  logic [1:0] char_count;
  logic       end_of_string;

  modport source (output valid, output first_char, output second_char,
                  output third_char, output char_count, output end_of_string,
                  input ready);
  modport sink   (input valid, input first_char, input second_char,
                  input third_char, input char_count, input end_of_string,
                  output ready);
endinterface

`default_nettype wire

/* hdl/ptwd_front.sv */
`default_nettype none

module ptwd_front (
  ptwd_in_if.sink              in_word,
  output logic                 push,
  output ptwd_pkg::word_entry_t push_entry,
  input  wire logic            push_ready
);

  // Accept a word whenever the queue has room
  assign in_word.ready = push_ready;
  assign push          = in_word.valid & push_ready;

  // Classify the three codes, state-free
  always_comb begin
    push_entry.eos = in_word.packed_word[15];
    for (int k = 0; k < 3; k++) begin
      logic [4:0] code;
      code = in_word.packed_word[5*k +: 5];
      push_entry.codes[k].alpha = code[0] ? ptwd_pkg::ALPHA_SYMBOL : ptwd_pkg::ALPHA_UPPER;
      push_entry.codes[k].idx   = code - ptwd_pkg::CODE_FIRST_CHAR;
      unique case (code) inside
        ptwd_pkg::CODE_SPACE, ptwd_pkg::CODE_NEWLINE: begin
          push_entry.codes[k].cls = ptwd_pkg::CLS_SPACE_NL;
          push_entry.codes[k].idx = {4'b0, code[0]};
        end
        ptwd_pkg::CODE_SHIFT_UPPER, ptwd_pkg::CODE_SHIFT_SYM: begin
          push_entry.codes[k].cls = ptwd_pkg::CLS_SHIFT;
        end
        ptwd_pkg::CODE_LOCK_UPPER, ptwd_pkg::CODE_LOCK_SYM: begin
          push_entry.codes[k].cls = ptwd_pkg::CLS_LOCK;
        end
        default: begin
          push_entry.codes[k].cls = ptwd_pkg::CLS_CHAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/ptwd_queue.sv */
`default_nettype none

module ptwd_queue #(
  parameter int DEPTH = ptwd_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire ptwd_pkg::word_entry_t push_entry,
  output logic                       push_ready,
  input  wire logic                  pop,
  output ptwd_pkg::word_entry_t      pop_entry,
  output logic                       pop_valid,
  output ptwd_pkg::q_status_t        status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptwd_pkg::word_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign push_ready   = ~status.full;
  assign pop_valid    = ~status.empty;
  assign pop_entry    = mem_r[rd_ptr_r];
  assign do_push      = push & ~status.full;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* hdl/ptwd_back.sv */
`default_nettype none

module ptwd_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pop_valid,
  input  wire ptwd_pkg::word_entry_t pop_entry,
  output logic                       pop,
  output ptwd_pkg::back_status_t     status,
  ptwd_out_if.source                 out_word
);

  ptwd_pkg::alpha_t locked_r, locked_nxt;
  ptwd_pkg::alpha_t shift_alpha_r, shift_alpha_nxt;
  logic             shift_pend_r, shift_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       char_r [3];
  logic [6:0]       char_nxt [3];
  logic [1:0]       count_r, count_nxt;
  logic             eos_r;

  // Take a word whenever the output register is free or being drained
  assign pop = pop_valid & (~out_valid_r | out_word.ready);

  assign status.pop           = pop;
  assign status.locked        = locked_r;
  assign status.shift_pending = shift_pend_r;

  // Decode the three codes in order against the alphabet state
  always_comb begin
    ptwd_pkg::alpha_t lk;
    ptwd_pkg::alpha_t sa;
    ptwd_pkg::alpha_t use_alpha;
    logic             sp;
    logic [1:0]       cnt;
    logic [6:0]       c;
    logic             emit;
    lk  = locked_r;
    sa  = shift_alpha_r;
    sp  = shift_pend_r;
    cnt = '0;
    for (int i = 0; i < 3; i++) begin
      char_nxt[i] = '0;
    end
    for (int k = 2; k >= 0; k--) begin
      c         = '0;
      emit      = 1'b0;
      use_alpha = sp ? sa : lk;
      case (pop_entry.codes[k].cls)
        ptwd_pkg::CLS_SPACE_NL: begin
          c    = pop_entry.codes[k].idx[0] ? ptwd_pkg::ASCII_NL : ptwd_pkg::ASCII_SPACE;
          emit = 1'b1;
          lk   = ptwd_pkg::ALPHA_LOWER;
        end
        ptwd_pkg::CLS_SHIFT: begin
          sp = 1'b1;
          sa = pop_entry.codes[k].alpha;
        end
        ptwd_pkg::CLS_LOCK: begin
          lk = pop_entry.codes[k].alpha;
        end
        default: begin
          sp   = 1'b0;
          emit = 1'b1;
          case (use_alpha)
            ptwd_pkg::ALPHA_LOWER: c = ptwd_pkg::ASCII_LOWER_A + {2'b0, pop_entry.codes[k].idx};
            ptwd_pkg::ALPHA_UPPER: c = ptwd_pkg::ASCII_UPPER_A + {2'b0, pop_entry.codes[k].idx};
            default:               c = ptwd_pkg::sym_char(pop_entry.codes[k].idx);
          endcase
        end
      endcase
      if (emit) begin
        char_nxt[cnt] = c;
        cnt           = cnt + 1'b1;
      end
    end
    count_nxt = cnt;
    // End of string drops all alphabet state
    if (pop_entry.eos) begin
      locked_nxt      = ptwd_pkg::ALPHA_LOWER;
      shift_alpha_nxt = ptwd_pkg::ALPHA_LOWER;
      shift_pend_nxt  = 1'b0;
    end else begin
      locked_nxt      = lk;
      shift_alpha_nxt = sa;
      shift_pend_nxt  = sp;
    end
  end

  // Hold the result until taken
  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r      <= ptwd_pkg::ALPHA_LOWER;
      shift_alpha_r <= ptwd_pkg::ALPHA_LOWER;
      shift_pend_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        locked_r      <= locked_nxt;
        shift_alpha_r <= shift_alpha_nxt;
        shift_pend_r  <= shift_pend_nxt;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      char_r  <= char_nxt;
      count_r <= count_nxt;
      eos_r   <= pop_entry.eos;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.first_char    = char_r[0];
  assign out_word.second_char   = char_r[1];
  assign out_word.third_char    = char_r[2];
  assign out_word.char_count    = count_r;
  assign out_word.end_of_string = eos_r;

endmodule

`default_nettype wire

/* hdl/packed_text_word_decoder.sv */
// An accepted word is written into the queue, then decoded from it into the
// output register. Throughput: one word per cycle while out_word is ready; the
// decode stage takes a whole word (three codes) at once; a QUEUE_DEPTH-entry
// queue decouples it from the input side so either side can stall alone.
// Reset: synchronous, active-low rst_n empties the queue, drops the output
// register and returns the alphabet to lowercase with no shift pending.
`default_nettype none

module packed_text_word_decoder #(
  parameter int QUEUE_DEPTH = ptwd_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptwd_in_if.sink     in_word,
  ptwd_out_if.source  out_word
);

  logic                   push;
  logic                   push_ready;
  ptwd_pkg::word_entry_t  push_entry;
  logic                   pop;
  logic                   pop_valid;
  ptwd_pkg::word_entry_t  pop_entry;
  ptwd_pkg::q_status_t    q_status;
  ptwd_pkg::back_status_t b_status;

  ptwd_front u_front (
    .in_word    (in_word),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  ptwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .status     (q_status)
  );

  ptwd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .status    (b_status),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // The decode stage never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    b_status.pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // No word is accepted while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_word.valid && in_word.ready) |-> !q_status.full)
    else $error("word accepted into full queue");

  // A word with the end mark leaves the alphabet state at reset values
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (b_status.pop && pop_entry.eos) |=>
      (b_status.locked == ptwd_pkg::ALPHA_LOWER && !b_status.shift_pending))
    else $error("alphabet state not cleared after end of string");
`endif

endmodule

`default_nettype wire

/* tb/packed_text_word_decoder_tb.sv */
`timescale 1ns / 1ps

module packed_text_word_decoder_tb;
  import ptwd_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_WORDS = 400;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 60;
  localparam int QUIET_FIRST  = 200;
  localparam int QUIET_LAST   = 300;

  // Symbol alphabet, character k at byte 23-k
  localparam logic [8*24-1:0] SYMBOL_SET = "0123456789.,!?_#'\"/\\-:()";

  typedef struct packed {
    logic [6:0] first_char;
    logic [6:0] second_char;
    logic [6:0] third_char;
    logic [1:0] char_count;
    logic       end_of_string;
  } text_result_t;

  logic clk;
  logic rst_n;

  ptwd_in_if  in_word();
  ptwd_out_if out_word();

  packed_text_word_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // Predictor state
  alpha_t lock_alpha;
  logic   shift_armed;
  alpha_t shift_alpha;

  logic [15:0]  pending_words [$];
  text_result_t expected_text [$];

  int errors;
  int words_sent;
  int results_seen;
  int hold_left;
  bit hold_done;
  int idle_cycles;
  bit send_quiet;
  text_result_t got_res;
  text_result_t want_res;

  // Decode one word against the alphabet state and advance that state
  function automatic text_result_t predict_text(input logic [15:0] w);
    text_result_t    r;
    logic [2:0][6:0] chars;
    logic [4:0]      code;
    logic [4:0]      k;
    alpha_t          use_alpha;
    int              n;
    chars = '0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      code = w[14 - 5 * i -: 5];
      if (code == CODE_SPACE || code == CODE_NEWLINE) begin
        chars[n] = (code == CODE_SPACE) ? ASCII_SPACE : ASCII_NL;
        n++;
        lock_alpha = ALPHA_LOWER;
      end else if (code == CODE_SHIFT_UPPER || code == CODE_SHIFT_SYM) begin
        shift_armed = 1'b1;
        if (code == CODE_SHIFT_UPPER) shift_alpha = ALPHA_UPPER;
        else shift_alpha = ALPHA_SYMBOL;
      end else if (code == CODE_LOCK_UPPER || code == CODE_LOCK_SYM) begin
        if (code == CODE_LOCK_UPPER) lock_alpha = ALPHA_UPPER;
        else lock_alpha = ALPHA_SYMBOL;
      end else begin
        use_alpha = shift_armed ? shift_alpha : lock_alpha;
        shift_armed = 1'b0;
        k = code - CODE_FIRST_CHAR;
        if (use_alpha == ALPHA_LOWER) begin
          chars[n] = ASCII_LOWER_A + k;
        end else if (use_alpha == ALPHA_UPPER) begin
          chars[n] = ASCII_UPPER_A + k;
        end else if (k < 24) begin
          chars[n] = SYMBOL_SET[8 * (23 - k) +: 7];
        end else begin
          // past the symbol table
          chars[n] = ASCII_QUEST;
        end
        n++;
      end
    end
    r.first_char    = chars[0];
    r.second_char   = chars[1];
    r.third_char    = chars[2];
    r.char_count    = n[1:0];
    r.end_of_string = w[15];
    // end mark returns the decoder to its reset state
    if (w[15]) begin
      lock_alpha  = ALPHA_LOWER;
      shift_armed = 1'b0;
      shift_alpha = ALPHA_LOWER;
    end
    return r;
  endfunction

  function automatic logic [15:0] pack_word(input logic eos, input logic [4:0] a,
                                            input logic [4:0] b, input logic [4:0] c);
    return {eos, a, b, c};
  endfunction

  task automatic report_field(input string fld, input logic [6:0] want,
                              input logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fld, want, got);
      errors++;
    end
  endtask

  // Block until every word is sent and every result has come back
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_word.valid || expected_text.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: offer queued words, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_word.valid <= 1'b0;
    end else if (!in_word.valid || in_word.ready) begin
      if (in_word.valid) begin
        expected_text.push_back(predict_text(in_word.packed_word));
        words_sent++;
      end
      send_quiet = words_sent >= QUIET_FIRST && words_sent < QUIET_LAST;
      if (pending_words.size() != 0 && (send_quiet || $urandom_range(0, 99) >= 7)) begin
        in_word.packed_word <= pending_words.pop_front();
        in_word.valid       <= 1'b1;
      end else begin
        in_word.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest prediction, drive ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_word.ready <= 1'b0;
    end else begin
      if (out_word.valid && out_word.ready) begin
        got_res.first_char    = out_word.first_char;
        got_res.second_char   = out_word.second_char;
        got_res.third_char    = out_word.third_char;
        got_res.char_count    = out_word.char_count;
        got_res.end_of_string = out_word.end_of_string;
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected result: expected none, got 0x%0h", $time, got_res);
          errors++;
        end else begin
          want_res = expected_text.pop_front();
          report_field("first_char", want_res.first_char, got_res.first_char);
          report_field("second_char", want_res.second_char, got_res.second_char);
          report_field("third_char", want_res.third_char, got_res.third_char);
          report_field("char_count", 7'(want_res.char_count), 7'(got_res.char_count));
          report_field("end_of_string", 7'(want_res.end_of_string),
                       7'(got_res.end_of_string));
        end
        results_seen++;
      end
      // hold off once for a long stretch so the block backs up
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) ||
                          $urandom_range(0, 99) >= 7;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] w;
    in_word.valid       = 1'b0;
    in_word.packed_word = '0;
    out_word.ready      = 1'b0;
    rst_n               = 1'b0;
    errors       = 0;
    words_sent   = 0;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    idle_cycles  = 0;
    lock_alpha   = ALPHA_LOWER;
    shift_armed  = 1'b0;
    shift_alpha  = ALPHA_LOWER;

    // Directed words: extremes, every code class, shift and lock corners
    pending_words.push_back(pack_word(1'b0, CODE_SPACE, CODE_SPACE, CODE_SPACE));
    pending_words.push_back(pack_word(1'b0, CODE_NEWLINE, CODE_NEWLINE, CODE_NEWLINE));
    pending_words.push_back(pack_word(1'b0, CODE_SHIFT_UPPER, CODE_FIRST_CHAR, 5'd7));
    pending_words.push_back(pack_word(1'b0, CODE_SHIFT_SYM, 5'd30, 5'd31));
    pending_words.push_back(pack_word(1'b0, CODE_LOCK_SYM, 5'd29, 5'd31));
    pending_words.push_back(pack_word(1'b0, CODE_FIRST_CHAR, 5'd15, 5'd30));
    // space with a shift armed keeps the shift
    pending_words.push_back(pack_word(1'b0, CODE_SHIFT_UPPER, CODE_SPACE, CODE_FIRST_CHAR));
    // no characters at all
    pending_words.push_back(pack_word(1'b0, CODE_SHIFT_UPPER, CODE_SHIFT_SYM, CODE_LOCK_UPPER));
    pending_words.push_back(pack_word(1'b0, 5'd20, CODE_FIRST_CHAR, CODE_NEWLINE));
    pending_words.push_back(pack_word(1'b1, CODE_LOCK_UPPER, CODE_SHIFT_SYM, 5'd8));
    pending_words.push_back(pack_word(1'b0, CODE_FIRST_CHAR, 5'd31, CODE_FIRST_CHAR));
    pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'h7FFF);
    pending_words.push_back(pack_word(1'b0, CODE_LOCK_UPPER, 5'd31, CODE_SHIFT_SYM));
    pending_words.push_back(pack_word(1'b1, CODE_LOCK_SYM, CODE_LOCK_UPPER, CODE_FIRST_CHAR));
    pending_words.push_back(pack_word(1'b0, CODE_LOCK_SYM, CODE_SHIFT_UPPER, 5'd10));
    pending_words.push_back(pack_word(1'b0, 5'd7, 5'd19, 5'd25));
    pending_words.push_back(pack_word(1'b1, 5'd22, 5'd23, 5'd29));
    pending_words.push_back(16'h8000);
    pending_words.push_back(pack_word(1'b0, CODE_SHIFT_SYM, CODE_SHIFT_SYM, 5'd31));
    pending_words.push_back(pack_word(1'b1, CODE_LOCK_SYM, CODE_NEWLINE, 5'd30));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Pause the sender until the directed words are all back
    @(negedge clk);
    wait_drained();

    // Random words: mostly code streams heavy in shifts and locks
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        w = 16'($urandom_range(0, 16'hFFFF));
      end else begin
        w[15] = ($urandom_range(0, 7) == 0);
        for (int j = 0; j < 3; j++)
          w[14 - 5 * j -: 5] = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 5)) :
                                                           5'($urandom_range(6, 31));
      end
      pending_words.push_back(w);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
hdl/ptwd_pkg.sv
hdl/ptwd_ifs.sv
hdl/ptwd_front.sv
hdl/ptwd_queue.sv
hdl/ptwd_back.sv
hdl/packed_text_word_decoder.sv
tb/packed_text_word_decoder_tb.sv
